@@ sv/wecp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wecp_pkg
// Shared widths, constants, register indexes and fixed-point helpers for the
// wireframe edge clip and projection pipeline.
// ----------------------------------------------------------------------------
package wecp_pkg;

	localparam int COORD_W  = 32;              // coordinate word, signed
	localparam int FRAC_W   = 16;              // coordinate fraction bits
	localparam int TRIG_W   = 16;              // trig word, signed Q1.14
	localparam int TRIG_FRAC = 14;
	localparam int WIDE_W   = COORD_W + 1;     // differences and moved points
	localparam int MUL_W    = TRIG_W + COORD_W;
	localparam int SAT_W    = MUL_W + 1;       // headroom for any sum before clamping
	localparam int PROD_W   = 2 * COORD_W;     // magnitude of a*b in the divider
	localparam int QUO_W    = COORD_W;         // quotient bits developed
	localparam int DIV_LAT  = QUO_W + 3;       // multiply, setup, bit steps, round
	localparam int CFG_W    = 64;
	localparam int FOCAL_W  = 31;
	localparam int IDX_W    = 3;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic        [WIDE_W-1:0]  uwide_t;
	typedef logic signed [TRIG_W-1:0]  trig_t;
	typedef logic signed [MUL_W-1:0]   mul_t;

	localparam logic [IDX_W-1:0] REG_VIEW_TRIG     = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_CAMERA_X      = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_CAMERA_Y      = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_CAMERA_Z      = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_SCREEN_ORIGIN = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_FOCAL_LENGTH  = IDX_W'(5);

	localparam logic signed [SAT_W-1:0] CMAX_W = SAT_W'((longint'(1) <<< (COORD_W - 1)) - 1);
	localparam logic signed [SAT_W-1:0] CMIN_W = ~CMAX_W;
	localparam logic signed [SAT_W-1:0] TRIG_HALF_W = SAT_W'(longint'(1) <<< (TRIG_FRAC - 1));
	localparam coord_t NEG_ONE  = COORD_W'(-(longint'(1) <<< FRAC_W));
	localparam uwide_t ONE_WIDE = WIDE_W'(longint'(1) <<< FRAC_W);
	localparam uwide_t LIM_POS  = WIDE_W'((longint'(1) <<< (COORD_W - 1)) - 1);
	localparam uwide_t LIM_NEG  = WIDE_W'(longint'(1) <<< (COORD_W - 1));
	localparam logic [FOCAL_W-1:0] FOCAL_RESET = FOCAL_W'(longint'(1) <<< FRAC_W);

	function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] x);
		coord_t r;
		priority if (x > CMAX_W) begin
			r = CMAX_W[COORD_W-1:0];
		end else if (x < CMIN_W) begin
			r = CMIN_W[COORD_W-1:0];
		end else begin
			r = x[COORD_W-1:0];
		end
		return r;
	endfunction

	// drop the trig fraction, round half up, clamp
	function automatic coord_t rnd_trig(input logic signed [SAT_W-1:0] s);
		logic signed [SAT_W-1:0] r;
		r = s + TRIG_HALF_W;
		return sat_coord(r >>> TRIG_FRAC);
	endfunction

endpackage
`default_nettype wire

@@ sv/wecp_muldiv.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wecp_muldiv
// Pipelined round(a*b/c): one multiply stage, one setup stage, one quotient
// bit per stage, then round half away from zero and clamp to a coordinate.
// ----------------------------------------------------------------------------
module wecp_muldiv (
	input  logic            clk,
	input  logic            en,
	input  wecp_pkg::wide_t  mul_a,
	input  wecp_pkg::wide_t  mul_b,
	input  wecp_pkg::uwide_t div_c,
	output wecp_pkg::coord_t quo
);
	import wecp_pkg::*;

	uwide_t mag_a, mag_b;
	logic [2*WIDE_W-1:0] prod_full;

	logic [PROD_W-1:0] prod_s1;
	uwide_t c_s1;
	logic neg_s1;

	uwide_t           rem_s  [QUO_W+1];
	logic [QUO_W-1:0] low_s  [QUO_W+1];
	logic [QUO_W-1:0] qb_s   [QUO_W+1];
	uwide_t           c_s    [QUO_W+1];
	logic             neg_s  [QUO_W+1];
	logic             ovf_s  [QUO_W+1];
	logic             zero_s [QUO_W+1];

	logic half_up;
	uwide_t q_rnd, q_lim, q_sat, q_res;
	coord_t quo_last_s;

	always_comb begin
		mag_a = mul_a[WIDE_W-1] ? uwide_t'(-mul_a) : uwide_t'(mul_a);
		mag_b = mul_b[WIDE_W-1] ? uwide_t'(-mul_b) : uwide_t'(mul_b);
		prod_full = {{WIDE_W{1'b0}}, mag_a} * {{WIDE_W{1'b0}}, mag_b};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= prod_full[PROD_W-1:0];
			c_s1    <= div_c;
			neg_s1  <= mul_a[WIDE_W-1] ^ mul_b[WIDE_W-1];
		end
	end

	// high half at or above divisor means the quotient cannot fit
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {1'b0, prod_s1[PROD_W-1:QUO_W]};
			ovf_s[0]  <= {1'b0, prod_s1[PROD_W-1:QUO_W]} >= c_s1;
			low_s[0]  <= prod_s1[QUO_W-1:0];
			qb_s[0]   <= '0;
			c_s[0]    <= c_s1;
			neg_s[0]  <= neg_s1;
			zero_s[0] <= (c_s1 == '0);
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic [WIDE_W:0] trial;
		logic take;

		always_comb begin
			trial = {rem_s[k], low_s[k][QUO_W-1]};
			take  = trial >= {1'b0, c_s[k]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? WIDE_W'(trial - {1'b0, c_s[k]}) : trial[WIDE_W-1:0];
				low_s[k+1]  <= {low_s[k][QUO_W-2:0], 1'b0};
				qb_s[k+1]   <= {qb_s[k][QUO_W-2:0], take};
				c_s[k+1]    <= c_s[k];
				neg_s[k+1]  <= neg_s[k];
				ovf_s[k+1]  <= ovf_s[k];
				zero_s[k+1] <= zero_s[k];
			end
		end
	end

	always_comb begin
		half_up = {rem_s[QUO_W], 1'b0} >= {1'b0, c_s[QUO_W]};
		q_rnd   = {1'b0, qb_s[QUO_W]} + WIDE_W'(half_up);
		q_lim   = neg_s[QUO_W] ? LIM_NEG : LIM_POS;
		q_sat   = (ovf_s[QUO_W] || q_rnd > q_lim) ? q_lim : q_rnd;
		priority if (zero_s[QUO_W]) begin
			q_res = '0;
		end else if (neg_s[QUO_W]) begin
			q_res = -q_sat;
		end else begin
			q_res = q_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_last_s <= q_res[COORD_W-1:0];
		end
	end

	assign quo = quo_last_s;

endmodule
`default_nettype wire

@@ sv/wireframe_edge_clip_project.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wireframe_edge_clip_project
// Moves a 3D segment into view space, clips it at the near plane z = -1 and
// projects both endpoints to screen coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry one segment (start, end, object offset). Output words
//   carry line_visible and the four screen coordinates; a rejected segment
//   comes out with visible low and all coordinates zero.
//   Registers are written via cfg_we/cfg_index/cfg_data by the user, only while
//   no word is in flight (not enforced); indexes past focal_length are dropped.
// Timing:
//   One word per cycle while the output is not held. Stages in order:
//   six stages of offset, rotation and clip setup, the clip divider, one
//   stage picking the moved endpoint, the projection dividers and the output
//   register. The dividers resolve one quotient bit per stage.
// Reset and stalls:
//   arst_n clears all valid bits and loads the register reset values.
//   The whole pipeline holds while the output word waits; in_ready is low
//   only then, and no word is dropped or repeated.
// ----------------------------------------------------------------------------
module wireframe_edge_clip_project (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wecp_pkg::IDX_W-1:0]   cfg_index,
	input  logic [wecp_pkg::CFG_W-1:0]   cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  wecp_pkg::coord_t             start_x,
	input  wecp_pkg::coord_t             start_y,
	input  wecp_pkg::coord_t             start_z,
	input  wecp_pkg::coord_t             end_x,
	input  wecp_pkg::coord_t             end_y,
	input  wecp_pkg::coord_t             end_z,
	input  wecp_pkg::coord_t             offset_x,
	input  wecp_pkg::coord_t             offset_y,
	input  wecp_pkg::coord_t             offset_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         line_visible,
	output wecp_pkg::coord_t             screen_x0,
	output wecp_pkg::coord_t             screen_y0,
	output wecp_pkg::coord_t             screen_x1,
	output wecp_pkg::coord_t             screen_y1
);
	import wecp_pkg::*;

	typedef struct packed {
		logic   rej;
		logic   clip_a;
		logic   clip_b;
		coord_t ax;
		coord_t ay;
		coord_t az;
		coord_t bx;
		coord_t by;
		coord_t bz;
	} clip_side_t;

	// configuration
	logic [CFG_W-1:0]   view_trig_q;
	coord_t             camera_x_q, camera_y_q, camera_z_q;
	logic [CFG_W-1:0]   screen_origin_q;
	logic [FOCAL_W-1:0] focal_length_q;

	trig_t  cyaw, syaw, cpit, spit;
	coord_t org_x, org_y;
	coord_t cam [3];
	coord_t off [3];
	coord_t in_pt [2][3];

	logic adv;

	// pipeline
	logic   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	coord_t pa_s1 [2][3];
	mul_t   m_s2  [2][4];
	coord_t dy_s2 [2];
	coord_t u_s3  [2];
	coord_t vx_s3 [2];
	coord_t dy_s3 [2];
	mul_t   n_s4  [2][4];
	coord_t vx_s4 [2];
	coord_t v_s5  [2][3];

	logic       rej_c, ca_c, cb_c;
	coord_t     mv_x, mv_y, mv_z, bs_x, bs_y, bs_z;
	wide_t      d_s6 [2];
	wide_t      num_s6;
	uwide_t     den_s6;
	clip_side_t side_s6;

	clip_side_t cside_s [DIV_LAT];
	logic       cvld_s  [DIV_LAT];
	coord_t     cq [2];

	clip_side_t cl;
	wide_t      pt_c [2][2];
	uwide_t     zd_c [2];
	wide_t      pt_s7 [2][2];
	uwide_t     zd_s7 [2];
	logic       rej_s7;

	logic   prej_s [DIV_LAT];
	logic   pvld_s [DIV_LAT];
	coord_t pq [2][2];
	wide_t  focal_w;

	coord_t scr_s8 [2][2];
	logic   vis_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_trig_q     <= '0;
			camera_x_q      <= '0;
			camera_y_q      <= '0;
			camera_z_q      <= '0;
			screen_origin_q <= '0;
			focal_length_q  <= FOCAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_VIEW_TRIG:     view_trig_q     <= cfg_data;
				REG_CAMERA_X:      camera_x_q      <= cfg_data[COORD_W-1:0];
				REG_CAMERA_Y:      camera_y_q      <= cfg_data[COORD_W-1:0];
				REG_CAMERA_Z:      camera_z_q      <= cfg_data[COORD_W-1:0];
				REG_SCREEN_ORIGIN: screen_origin_q <= cfg_data;
				REG_FOCAL_LENGTH:  focal_length_q  <= cfg_data[FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cyaw  = view_trig_q[63:48];
		syaw  = view_trig_q[47:32];
		cpit  = view_trig_q[31:16];
		spit  = view_trig_q[15:0];
		org_x = screen_origin_q[63:32];
		org_y = screen_origin_q[31:0];
		cam[0] = camera_x_q;
		cam[1] = camera_y_q;
		cam[2] = camera_z_q;
		off[0] = offset_x;
		off[1] = offset_y;
		off[2] = offset_z;
		in_pt[0][0] = start_x;
		in_pt[0][1] = start_y;
		in_pt[0][2] = start_z;
		in_pt[1][0] = end_x;
		in_pt[1][1] = end_y;
		in_pt[1][2] = end_z;
		focal_w = wide_t'(focal_length_q);
	end

	assign adv      = !vld_s8 || out_ready;
	assign in_ready = adv;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) begin
				cvld_s[k] <= 1'b0;
				pvld_s[k] <= 1'b0;
			end
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			cvld_s[0] <= vld_s6;
			for (int k = 1; k < DIV_LAT; k++) begin
				cvld_s[k] <= cvld_s[k-1];
				pvld_s[k] <= pvld_s[k-1];
			end
			vld_s7    <= cvld_s[DIV_LAT-1];
			pvld_s[0] <= vld_s7;
			vld_s8    <= pvld_s[DIV_LAT-1];
		end
	end

	// relative position, then the two rotation passes
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int e = 0; e < 2; e++) begin
				for (int i = 0; i < 3; i++) begin
					pa_s1[e][i] <= sat_coord(SAT_W'(in_pt[e][i]) + SAT_W'(off[i])
						- SAT_W'(cam[i]));
				end
				m_s2[e][0] <= syaw * pa_s1[e][0];
				m_s2[e][1] <= cyaw * pa_s1[e][2];
				m_s2[e][2] <= cyaw * pa_s1[e][0];
				m_s2[e][3] <= syaw * pa_s1[e][2];
				dy_s2[e]   <= pa_s1[e][1];

				u_s3[e]  <= rnd_trig(SAT_W'(m_s2[e][0]) + SAT_W'(m_s2[e][1]));
				vx_s3[e] <= rnd_trig(SAT_W'(m_s2[e][2]) - SAT_W'(m_s2[e][3]));
				dy_s3[e] <= dy_s2[e];

				n_s4[e][0] <= spit * u_s3[e];
				n_s4[e][1] <= cpit * dy_s3[e];
				n_s4[e][2] <= cpit * u_s3[e];
				n_s4[e][3] <= spit * dy_s3[e];
				vx_s4[e]   <= vx_s3[e];

				v_s5[e][0] <= vx_s4[e];
				v_s5[e][1] <= rnd_trig(SAT_W'(n_s4[e][0]) + SAT_W'(n_s4[e][1]));
				v_s5[e][2] <= rnd_trig(SAT_W'(n_s4[e][2]) - SAT_W'(n_s4[e][3]));
			end
		end
	end

	// near plane test; the moved endpoint is the one in front of z = -1
	always_comb begin
		rej_c = (v_s5[0][2] >= NEG_ONE) && (v_s5[1][2] >= NEG_ONE);
		ca_c  = !rej_c && (v_s5[0][2] > NEG_ONE);
		cb_c  = !rej_c && !ca_c && (v_s5[1][2] > NEG_ONE);
		mv_x  = cb_c ? v_s5[1][0] : v_s5[0][0];
		mv_y  = cb_c ? v_s5[1][1] : v_s5[0][1];
		mv_z  = cb_c ? v_s5[1][2] : v_s5[0][2];
		bs_x  = cb_c ? v_s5[0][0] : v_s5[1][0];
		bs_y  = cb_c ? v_s5[0][1] : v_s5[1][1];
		bs_z  = cb_c ? v_s5[0][2] : v_s5[1][2];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s6[0] <= wide_t'(mv_x) - wide_t'(bs_x);
			d_s6[1] <= wide_t'(mv_y) - wide_t'(bs_y);
			num_s6  <= wide_t'(NEG_ONE) - wide_t'(bs_z);
			den_s6  <= uwide_t'(wide_t'(mv_z) - wide_t'(bs_z));
			side_s6 <= '{rej: rej_c, clip_a: ca_c, clip_b: cb_c,
				ax: v_s5[0][0], ay: v_s5[0][1], az: v_s5[0][2],
				bx: v_s5[1][0], by: v_s5[1][1], bz: v_s5[1][2]};
			cside_s[0] <= side_s6;
			for (int k = 1; k < DIV_LAT; k++) begin
				cside_s[k] <= cside_s[k-1];
			end
		end
	end

	for (genvar a = 0; a < 2; a++) begin : g_clip
		wecp_muldiv u_clip (
			.clk   (clk),
			.en    (adv),
			.mul_a (d_s6[a]),
			.mul_b (num_s6),
			.div_c (den_s6),
			.quo   (cq[a])
		);
	end

	// clipped endpoint sits on z = -1, so its divisor is one
	always_comb begin
		cl = cside_s[DIV_LAT-1];
		pt_c[0][0] = wide_t'(cl.ax);
		pt_c[0][1] = wide_t'(cl.ay);
		pt_c[1][0] = wide_t'(cl.bx);
		pt_c[1][1] = wide_t'(cl.by);
		zd_c[0]    = uwide_t'(-wide_t'(cl.az));
		zd_c[1]    = uwide_t'(-wide_t'(cl.bz));
		priority if (cl.clip_a) begin
			pt_c[0][0] = wide_t'(cl.bx) + wide_t'(cq[0]);
			pt_c[0][1] = wide_t'(cl.by) + wide_t'(cq[1]);
			zd_c[0]    = ONE_WIDE;
		end else if (cl.clip_b) begin
			pt_c[1][0] = wide_t'(cl.ax) + wide_t'(cq[0]);
			pt_c[1][1] = wide_t'(cl.ay) + wide_t'(cq[1]);
			zd_c[1]    = ONE_WIDE;
		end else begin
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pt_s7  <= pt_c;
			zd_s7  <= zd_c;
			rej_s7 <= cl.rej;
			prej_s[0] <= rej_s7;
			for (int k = 1; k < DIV_LAT; k++) begin
				prej_s[k] <= prej_s[k-1];
			end
		end
	end

	for (genvar e = 0; e < 2; e++) begin : g_proj_pt
		for (genvar a = 0; a < 2; a++) begin : g_proj_ax
			wecp_muldiv u_proj (
				.clk   (clk),
				.en    (adv),
				.mul_a (focal_w),
				.mul_b (pt_s7[e][a]),
				.div_c (zd_s7[e]),
				.quo   (pq[e][a])
			);
		end
	end

	// screen y grows downward
	always_ff @(posedge clk) begin
		if (adv) begin
			vis_s8 <= !prej_s[DIV_LAT-1];
			for (int e = 0; e < 2; e++) begin
				if (prej_s[DIV_LAT-1]) begin
					scr_s8[e][0] <= '0;
					scr_s8[e][1] <= '0;
				end else begin
					scr_s8[e][0] <= sat_coord(SAT_W'(org_x) + SAT_W'(pq[e][0]));
					scr_s8[e][1] <= sat_coord(SAT_W'(org_y) - SAT_W'(pq[e][1]));
				end
			end
		end
	end

	assign out_valid    = vld_s8;
	assign line_visible = vis_s8;
	assign screen_x0    = scr_s8[0][0];
	assign screen_y0    = scr_s8[0][1];
	assign screen_x1    = scr_s8[1][0];
	assign screen_y1    = scr_s8[1][1];

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !line_visible |-> screen_x0 == '0 && screen_y0 == '0
			&& screen_x1 == '0 && screen_y1 == '0)
		else $error("rejected segment carries nonzero coordinates");

	a_clip_excl: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s6 |-> $onehot0({side_s6.rej, side_s6.clip_a, side_s6.clip_b}))
		else $error("clip decisions overlap");

	a_proj_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s7 && !rej_s7 |-> zd_s7[0] >= ONE_WIDE && zd_s7[1] >= ONE_WIDE)
		else $error("projection divisor below one");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_s1)
		else $error("accepted word not in first stage");

endmodule
`default_nettype wire
